### hw/rtl/stok_pkg.sv
// Package: shared types, constants and helpers for the source tokenizer.
package stok_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int LENGTH_BITS = 16;
  localparam int LC_BITS     = 24;
  localparam int KIND_BITS   = 6;
  localparam int NUM_KW      = 12;
  localparam int QDEPTH      = 4;  // power of two, at least 4
  localparam int QPTR_BITS   = $clog2(QDEPTH);

  // out_tdata: line, column, start_offset, length, bad_char, padded to bytes
  localparam int REC_DATA_BITS = 2*LC_BITS + OFFSET_BITS + LENGTH_BITS + 8;
  localparam int TDATA_BITS    = ((REC_DATA_BITS + 7) / 8) * 8;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [LC_BITS-1:0]     LC_MAX  = {LC_BITS{1'b1}};

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_NUMDOT, M_STRING, M_HOLDOP,
    M_LINECMT, M_BLOCKCMT, M_BLOCKSTAR, M_DONE
  } mode_t;

  localparam logic [KIND_BITS-1:0] K_IDENT    = 6'd0;
  localparam logic [KIND_BITS-1:0] K_NUMBER   = 6'd1;
  localparam logic [KIND_BITS-1:0] K_STRING   = 6'd2;
  localparam logic [KIND_BITS-1:0] K_KW0      = 6'd3;
  localparam logic [KIND_BITS-1:0] K_PLUS     = 6'd15;
  localparam logic [KIND_BITS-1:0] K_MINUS    = 6'd16;
  localparam logic [KIND_BITS-1:0] K_STAR     = 6'd17;
  localparam logic [KIND_BITS-1:0] K_SLASH    = 6'd18;
  localparam logic [KIND_BITS-1:0] K_EQ       = 6'd19;
  localparam logic [KIND_BITS-1:0] K_EQEQ     = 6'd20;
  localparam logic [KIND_BITS-1:0] K_BANGEQ   = 6'd21;
  localparam logic [KIND_BITS-1:0] K_GT       = 6'd22;
  localparam logic [KIND_BITS-1:0] K_LT       = 6'd23;
  localparam logic [KIND_BITS-1:0] K_GE       = 6'd24;
  localparam logic [KIND_BITS-1:0] K_LE       = 6'd25;
  localparam logic [KIND_BITS-1:0] K_LPAREN   = 6'd26;
  localparam logic [KIND_BITS-1:0] K_RPAREN   = 6'd27;
  localparam logic [KIND_BITS-1:0] K_LBRACE   = 6'd28;
  localparam logic [KIND_BITS-1:0] K_RBRACE   = 6'd29;
  localparam logic [KIND_BITS-1:0] K_SEMI     = 6'd30;
  localparam logic [KIND_BITS-1:0] K_COMMA    = 6'd31;
  localparam logic [KIND_BITS-1:0] K_EOF      = 6'd32;
  localparam logic [KIND_BITS-1:0] K_ERR_CHAR = 6'd33;
  localparam logic [KIND_BITS-1:0] K_ERR_BANG = 6'd34;
  localparam logic [KIND_BITS-1:0] K_ERR_STR  = 6'd35;
  localparam logic [KIND_BITS-1:0] K_ERR_CMT  = 6'd36;

  // one token record
  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [LC_BITS-1:0]     line;
    logic [LC_BITS-1:0]     column;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] len;
    logic [7:0]             bad;
    logic                   last;
  } rec_t;

  // up to three records produced by one input byte
  typedef struct packed {
    logic [1:0] cnt;
    rec_t       r2;
    rec_t       r1;
    rec_t       r0;
  } burst_t;

  // keyword text, byte i of keyword k; 0 beyond its length
  function automatic logic [7:0] kw_char(input int k, input int i);
    logic [63:0] t;
    t = 64'h0;
    case (k)
      0:  t = {40'h0, "tel"};
      1:  t = {24'h0, "tsnoc"};
      2:  t = "noitcnuf";
      3:  t = {16'h0, "nruter"};
      4:  t = {48'h0, "fi"};
      5:  t = {32'h0, "esle"};
      6:  t = {24'h0, "elihw"};
      7:  t = {40'h0, "rof"};
      8:  t = {40'h0, "tni"};
      9:  t = {24'h0, "taolf"};
      10: t = {16'h0, "gnirts"};
      default: t = {32'h0, "loob"};
    endcase
    return t[i*8 +: 8];
  endfunction

  function automatic logic [3:0] kw_len(input int k);
    logic [3:0] l;
    case (k)
      0, 7, 8:  l = 4'd3;
      1, 6, 9:  l = 4'd5;
      2:        l = 4'd8;
      3, 10:    l = 4'd6;
      4:        l = 4'd2;
      default:  l = 4'd4;
    endcase
    return l;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

### hw/rtl/source_tokenizer.sv
// Top level of the source tokenizer: stream ports, scanner, record queue.
//
// Usage:
//   Input channel in_*: one source byte per transaction. in_tdata[7:0] is the
//   byte, in_tuser is the end-of-source flag; a zero byte also ends the source.
//   Output channel out_*: one token record per transaction, out_tuser is the
//   record kind, out_tlast marks the last record caused by a given input byte.
//   The scanner takes one byte per cycle while the four-entry record queue
//   has room for a full burst (three records); the records of a byte are
//   registered into the queue and reach out_* after those queued before.
//   Throughput: one byte per cycle while the queue has room; bursts of two or
//   three records from one byte drain one per cycle while out_tready is high,
//   and the queue depth sets how long the input keeps flowing meanwhile.
//   When the receiver stalls, the queue fills and in_tready drops; nothing
//   is lost. Reset (rst_n low, synchronous) returns the scanner to idle at
//   line 1, column 1, offset 0, and empties the queue. After the end record
//   or an unterminated-comment record, further bytes are taken and dropped.
module source_tokenizer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] ch
  input  logic                             in_tuser,   // is_end
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [stok_pkg::TDATA_BITS-1:0]  out_tdata,  // line 24, column 24,
                                                       // start_offset 32,
                                                       // length 16, bad_char 8
  output logic [stok_pkg::KIND_BITS-1:0]   out_tuser,  // kind
  output logic                             out_tlast
);
  import stok_pkg::*;

  burst_t burst;
  rec_t   head;
  logic   room, step;

  assign in_tready = room;
  assign step      = in_tvalid && room;

  stok_front u_front (
    .clk, .rst_n, .step, .ch(in_tdata), .is_end(in_tuser), .burst
  );

  stok_queue u_queue (
    .clk, .rst_n, .push(step), .burst, .room,
    .pop_valid(out_tvalid), .pop_rec(head), .pop(out_tvalid && out_tready)
  );

  assign out_tdata = TDATA_BITS'({head.bad, head.len, head.start, head.column,
                                  head.line});
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

`ifndef SYNTH
  a_len_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (head.kind == K_ERR_CHAR || head.kind == K_ERR_BANG)
      |-> head.len == LENGTH_BITS'(1))
    else $error("error record with bad length");
  a_line_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> head.line != '0 && head.column != '0)
    else $error("zero line or column");
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && head.kind == K_EOF |-> head.last)
    else $error("end record not last");
`endif

endmodule

### hw/rtl/stok_front.sv
// Front part: scanner state machine, one byte per cycle while step is high, builds record bursts.
module stok_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      ch,
  input  logic            is_end,
  output stok_pkg::burst_t burst
);
  import stok_pkg::*;

  mode_t                  mode_r, mode_nxt;
  logic [7:0]             held_r, held_nxt;
  logic                   dot_r, dot_nxt;
  logic [NUM_KW-1:0]      kw_r, kw_nxt;
  logic [OFFSET_BITS-1:0] tstart_r, tstart_nxt;
  logic [LENGTH_BITS-1:0] tlen_r, tlen_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [LC_BITS-1:0]     line_r, line_nxt;
  logic [LC_BITS-1:0]     col_r, col_nxt;

  // scratch for combinational sequencing
  logic [OFFSET_BITS-1:0] p;
  logic [LC_BITS-1:0]     ln, cl;
  logic [1:0]             n;
  rec_t                   rr [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      held_r   <= 8'd0;
      dot_r    <= 1'b0;
      kw_r     <= {NUM_KW{1'b1}};
      tstart_r <= '0;
      tlen_r   <= '0;
      pos_r    <= '0;
      line_r   <= 24'd1;
      col_r    <= 24'd1;
    end else if (step) begin
      mode_r   <= mode_nxt;
      held_r   <= held_nxt;
      dot_r    <= dot_nxt;
      kw_r     <= kw_nxt;
      tstart_r <= tstart_nxt;
      tlen_r   <= tlen_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
    end
  end

  always_comb begin
    logic [7:0]             c, h;
    logic                   fin;
    logic [KIND_BITS-1:0]   k;
    logic                   do_start;
    logic [KIND_BITS-1:0]   ik;

    mode_nxt   = mode_r;
    held_nxt   = held_r;
    dot_nxt    = dot_r;
    kw_nxt     = kw_r;
    tstart_nxt = tstart_r;
    tlen_nxt   = tlen_r;
    p  = pos_r;
    ln = line_r;
    cl = col_r;
    n  = 2'd0;
    for (int j = 0; j < 3; j++) rr[j] = '0;
    c        = ch;
    h        = held_r;
    fin      = is_end || (ch == 8'd0);
    k        = K_PLUS;
    do_start = 1'b0;
    ik       = K_IDENT;

    for (int i = 0; i < NUM_KW; i++)
      if (kw_r[i] && tlen_r == LENGTH_BITS'(kw_len(i))) ik = KIND_BITS'(K_KW0 + i);

    unique case (mode_r)
      M_DONE: ;
      M_IDLE: do_start = !fin;
      M_IDENT: begin
        if (fin) begin
          rr[n] = '{ik, ln, cl, tstart_r, tlen_r, 8'd0, 1'b0}; n = n + 2'd1;
        end else if (is_alpha(c) || is_digit(c)) begin
          for (int i = 0; i < NUM_KW; i++)
            if (tlen_r >= LENGTH_BITS'(kw_len(i)) || kw_char(i, int'(tlen_r[2:0])) != c)
              kw_nxt[i] = 1'b0;
          if (tlen_r != LEN_MAX) tlen_nxt = tlen_r + 1'b1;
          if (p != OFF_MAX) p = p + 1'b1;
          if (c == 8'h0a) begin if (ln != LC_MAX) ln = ln + 1'b1; cl = 24'd1; end
          else if (cl != LC_MAX) cl = cl + 1'b1;
        end else begin
          rr[n] = '{ik, ln, cl, tstart_r, tlen_r, 8'd0, 1'b0}; n = n + 2'd1;
          mode_nxt = M_IDLE;
          do_start = 1'b1;
        end
      end
      M_NUMBER: begin
        if (fin) begin
          rr[n] = '{K_NUMBER, ln, cl, tstart_r, tlen_r, 8'd0, 1'b0}; n = n + 2'd1;
        end else if (is_digit(c)) begin
          if (tlen_r != LEN_MAX) tlen_nxt = tlen_r + 1'b1;
          if (p != OFF_MAX) p = p + 1'b1;
          if (cl != LC_MAX) cl = cl + 1'b1;
        end else if (c == "." && !dot_r) begin
          held_nxt = ".";
          mode_nxt = M_NUMDOT;
        end else begin
          rr[n] = '{K_NUMBER, ln, cl, tstart_r, tlen_r, 8'd0, 1'b0}; n = n + 2'd1;
          mode_nxt = M_IDLE;
          do_start = 1'b1;
        end
      end
      M_NUMDOT: begin
        held_nxt = 8'd0;
        if (!fin && is_digit(c)) begin
          if (p != OFF_MAX) p = p + 1'b1;
          if (cl != LC_MAX) cl = cl + 1'b1;
          tlen_nxt = tlen_r;
          if (tlen_nxt != LEN_MAX) tlen_nxt = tlen_nxt + 1'b1;
          if (tlen_nxt != LEN_MAX) tlen_nxt = tlen_nxt + 1'b1;
          dot_nxt = 1'b1;
          if (p != OFF_MAX) p = p + 1'b1;
          if (cl != LC_MAX) cl = cl + 1'b1;
          mode_nxt = M_NUMBER;
        end else begin
          rr[n] = '{K_NUMBER, ln, cl, tstart_r, tlen_r, 8'd0, 1'b0}; n = n + 2'd1;
          rr[n] = '{K_ERR_CHAR, ln, cl, p, LENGTH_BITS'(1), ".", 1'b0}; n = n + 2'd1;
          if (p != OFF_MAX) p = p + 1'b1;
          if (cl != LC_MAX) cl = cl + 1'b1;
          mode_nxt = M_IDLE;
          do_start = !fin;
        end
      end
      M_STRING: begin
        if (fin) begin
          rr[n] = '{K_ERR_STR, ln, cl, p, '0, 8'd0, 1'b0}; n = n + 2'd1;
          if (cl != LC_MAX) cl = cl + 1'b1;
          rr[n] = '{K_STRING, ln, cl, tstart_r, tlen_r, 8'd0, 1'b0}; n = n + 2'd1;
        end else begin
          if (p != OFF_MAX) p = p + 1'b1;
          if (c == 8'h0a) begin if (ln != LC_MAX) ln = ln + 1'b1; cl = 24'd1; end
          else if (cl != LC_MAX) cl = cl + 1'b1;
          if (c == 8'h22) begin
            rr[n] = '{K_STRING, ln, cl, tstart_r, tlen_r, 8'd0, 1'b0}; n = n + 2'd1;
            mode_nxt = M_IDLE;
          end else if (tlen_r != LEN_MAX) tlen_nxt = tlen_r + 1'b1;
        end
      end
      M_HOLDOP: begin
        held_nxt = 8'd0;
        mode_nxt = M_IDLE;
        if (h == "/" && !fin && (c == "/" || c == "*")) begin
          if (p != OFF_MAX) p = p + 1'b1;
          if (cl != LC_MAX) cl = cl + 1'b1;
          if (p != OFF_MAX) p = p + 1'b1;
          if (cl != LC_MAX) cl = cl + 1'b1;
          mode_nxt = (c == "/") ? M_LINECMT : M_BLOCKCMT;
        end else if (h != "/" && !fin && c == "=") begin
          if (p != OFF_MAX) p = p + 1'b1;
          if (cl != LC_MAX) cl = cl + 1'b1;
          k = (h == "=") ? K_EQEQ : (h == "!") ? K_BANGEQ : (h == "<") ? K_LE : K_GE;
          rr[n] = '{k, ln, cl, tstart_r, LENGTH_BITS'(2), 8'd0, 1'b0}; n = n + 2'd1;
          if (p != OFF_MAX) p = p + 1'b1;
          if (cl != LC_MAX) cl = cl + 1'b1;
        end else begin
          if (h == "/") k = K_SLASH;
          else if (h == "!") k = K_ERR_BANG;
          else if (h == "=") k = K_EQ;
          else if (h == "<") k = K_LT;
          else k = K_GT;
          rr[n] = '{k, ln, cl, tstart_r, LENGTH_BITS'(1), (h == "!") ? 8'h21 : 8'd0, 1'b0};
          n = n + 2'd1;
          if (p != OFF_MAX) p = p + 1'b1;
          if (cl != LC_MAX) cl = cl + 1'b1;
          do_start = !fin;
        end
      end
      M_LINECMT: begin
        if (!fin) begin
          if (c == 8'h0a) begin mode_nxt = M_IDLE; do_start = 1'b1; end
          else begin
            if (p != OFF_MAX) p = p + 1'b1;
            if (cl != LC_MAX) cl = cl + 1'b1;
          end
        end
      end
      M_BLOCKCMT: begin
        if (fin) begin
          rr[n] = '{K_ERR_CMT, ln, cl, p, '0, 8'd0, 1'b0}; n = n + 2'd1;
        end else if (c == "*") begin
          held_nxt = "*"; mode_nxt = M_BLOCKSTAR;
        end else begin
          if (p != OFF_MAX) p = p + 1'b1;
          if (c == 8'h0a) begin if (ln != LC_MAX) ln = ln + 1'b1; cl = 24'd1; end
          else if (cl != LC_MAX) cl = cl + 1'b1;
        end
      end
      M_BLOCKSTAR: begin
        if (p != OFF_MAX) p = p + 1'b1;
        if (cl != LC_MAX) cl = cl + 1'b1;
        held_nxt = 8'd0;
        if (fin) begin
          rr[n] = '{K_ERR_CMT, ln, cl, p, '0, 8'd0, 1'b0}; n = n + 2'd1;
        end else if (c == "/") begin
          if (p != OFF_MAX) p = p + 1'b1;
          if (cl != LC_MAX) cl = cl + 1'b1;
          mode_nxt = M_IDLE;
        end else if (c == "*") begin
          held_nxt = "*";
        end else begin
          if (p != OFF_MAX) p = p + 1'b1;
          if (c == 8'h0a) begin if (ln != LC_MAX) ln = ln + 1'b1; cl = 24'd1; end
          else if (cl != LC_MAX) cl = cl + 1'b1;
          mode_nxt = M_BLOCKCMT;
        end
      end
      default: ;
    endcase

    // start a new token from the current byte
    if (do_start) begin
      if (is_space(c)) begin
        if (p != OFF_MAX) p = p + 1'b1;
        if (c == 8'h0a) begin if (ln != LC_MAX) ln = ln + 1'b1; cl = 24'd1; end
        else if (cl != LC_MAX) cl = cl + 1'b1;
      end else if (is_digit(c)) begin
        tstart_nxt = p; tlen_nxt = LENGTH_BITS'(1); dot_nxt = 1'b0;
        if (p != OFF_MAX) p = p + 1'b1;
        if (cl != LC_MAX) cl = cl + 1'b1;
        mode_nxt = M_NUMBER;
      end else if (is_alpha(c)) begin
        tstart_nxt = p; tlen_nxt = LENGTH_BITS'(1);
        for (int i = 0; i < NUM_KW; i++) kw_nxt[i] = (kw_char(i, 0) == c);
        if (p != OFF_MAX) p = p + 1'b1;
        if (cl != LC_MAX) cl = cl + 1'b1;
        mode_nxt = M_IDENT;
      end else if (c == 8'h22) begin
        if (p != OFF_MAX) p = p + 1'b1;
        if (cl != LC_MAX) cl = cl + 1'b1;
        tstart_nxt = p; tlen_nxt = '0;
        mode_nxt = M_STRING;
      end else if (c == "/" || c == "=" || c == "!" || c == "<" || c == ">") begin
        tstart_nxt = p; held_nxt = c; mode_nxt = M_HOLDOP;
      end else begin
        case (c)
          "+": k = K_PLUS;
          "-": k = K_MINUS;
          "*": k = K_STAR;
          "(": k = K_LPAREN;
          ")": k = K_RPAREN;
          "{": k = K_LBRACE;
          "}": k = K_RBRACE;
          ";": k = K_SEMI;
          ",": k = K_COMMA;
          default: k = K_ERR_CHAR;
        endcase
        rr[n] = '{k, ln, cl, p, LENGTH_BITS'(1), (k == K_ERR_CHAR) ? c : 8'd0, 1'b0};
        n = n + 2'd1;
        if (p != OFF_MAX) p = p + 1'b1;
        if (cl != LC_MAX) cl = cl + 1'b1;
      end
    end

    // end of source closes the stream
    if (fin && mode_r != M_DONE) begin
      if (mode_r != M_BLOCKCMT && mode_r != M_BLOCKSTAR) begin
        rr[n] = '{K_EOF, ln, cl, p, '0, 8'd0, 1'b0}; n = n + 2'd1;
      end
      mode_nxt = M_DONE;
    end

    if (n != 2'd0) rr[n - 2'd1].last = 1'b1;
    pos_nxt  = p;
    line_nxt = ln;
    col_nxt  = cl;
  end

  assign burst = '{n, rr[2], rr[1], rr[0]};

endmodule

### hw/rtl/stok_queue.sv
// Record queue between the scanner and the output stage.
module stok_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  stok_pkg::burst_t burst,
  output logic             room,
  output logic             pop_valid,
  output stok_pkg::rec_t   pop_rec,
  input  logic             pop
);
  import stok_pkg::*;

  rec_t                 mem_r [QDEPTH];
  logic [QPTR_BITS-1:0] wp_r, rp_r;
  logic [QPTR_BITS:0]   cnt_r;
  logic [QPTR_BITS:0]   cnt_nxt;

  // a push needs room for a full burst of three
  assign room      = cnt_r <= (QPTR_BITS+1)'(QDEPTH - 3) ||
                     (pop && cnt_r == (QPTR_BITS+1)'(QDEPTH - 2));
  assign pop_valid = cnt_r != '0;
  assign pop_rec   = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push) cnt_nxt = cnt_nxt + (QPTR_BITS+1)'(burst.cnt);
    if (pop)  cnt_nxt = cnt_nxt - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QPTR_BITS'(burst.cnt);
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (burst.cnt > 2'd0) mem_r[wp_r]        <= burst.r0;
      if (burst.cnt > 2'd1) mem_r[wp_r + 2'd1] <= burst.r1;
      if (burst.cnt > 2'd2) mem_r[wp_r + 2'd2] <= burst.r2;
    end
  end

endmodule

### tb/tb_source_tokenizer.sv
// Testbench for the source tokenizer: random source text, token record checks.
module tb_source_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;
  import stok_pkg::*;

  // Token record predictor plus the queue of records it still waits for.
  class token_scoreboard;
    mode_t                  scan_mode;
    logic [7:0]             held;
    logic                   dot_seen;
    logic [NUM_KW-1:0]      kw_hits;
    logic [OFFSET_BITS-1:0] tok_start;
    logic [LENGTH_BITS-1:0] tok_len;
    logic [OFFSET_BITS-1:0] pos;
    logic [LC_BITS-1:0]     line_no;
    logic [LC_BITS-1:0]     col_no;
    rec_t                   burst[$];
    rec_t                   pending[$];
    string                  words[NUM_KW];
    int                     fails;
    int                     n_inputs;
    int                     n_records;
    logic [63:0]            kinds_seen;

    function new();
      words = '{"let", "const", "function", "return", "if", "else",
                "while", "for", "int", "float", "string", "bool"};
      scan_mode = M_IDLE;
      held = 8'h0;
      dot_seen = 1'b0;
      kw_hits = '1;
      tok_start = '0;
      tok_len = '0;
      pos = '0;
      line_no = 1;
      col_no = 1;
      fails = 0;
      n_inputs = 0;
      n_records = 0;
      kinds_seen = '0;
    endfunction

    function bit digit_c(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit alpha_c(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function bit space_c(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function void push_rec(logic [KIND_BITS-1:0] k, logic [OFFSET_BITS-1:0] s,
                           logic [LENGTH_BITS-1:0] l, logic [7:0] b);
      rec_t r;
      if (burst.size() >= 3) return;
      r.kind = k;
      r.line = line_no;
      r.column = col_no;
      r.start = s;
      r.len = l;
      r.bad = b;
      r.last = 1'b0;
      burst.insert(burst.size(), r);
    endfunction

    // passing over one byte moves offset, line and column
    function void pass_byte(logic [7:0] c);
      if (pos != OFF_MAX) pos++;
      if (c == 8'h0a) begin
        if (line_no != LC_MAX) line_no++;
        col_no = 1;
      end else if (col_no != LC_MAX) begin
        col_no++;
      end
    endfunction

    function void grow_len();
      if (tok_len != LEN_MAX) tok_len++;
    endfunction

    function void match_keywords(logic [7:0] c);
      for (int i = 0; i < NUM_KW; i++)
        if (tok_len >= words[i].len() || words[i][tok_len] != c) kw_hits[i] = 1'b0;
    endfunction

    function void close_ident();
      logic [KIND_BITS-1:0] k;
      k = K_IDENT;
      for (int i = 0; i < NUM_KW; i++)
        if (kw_hits[i] && tok_len == words[i].len()) k = KIND_BITS'(K_KW0 + i);
      push_rec(k, tok_start, tok_len, 8'h0);
    endfunction

    function void open_token(logic [7:0] c);
      logic [KIND_BITS-1:0] k;
      if (space_c(c)) begin
        pass_byte(c);
        return;
      end
      if (digit_c(c)) begin
        tok_start = pos;
        tok_len = 1;
        dot_seen = 1'b0;
        pass_byte(c);
        scan_mode = M_NUMBER;
        return;
      end
      if (alpha_c(c)) begin
        tok_start = pos;
        tok_len = 0;
        kw_hits = '1;
        match_keywords(c);
        tok_len = 1;
        pass_byte(c);
        scan_mode = M_IDENT;
        return;
      end
      case (c)
        "\"": begin
          pass_byte(c);
          tok_start = pos;
          tok_len = 0;
          scan_mode = M_STRING;
          return;
        end
        "/", "=", "!", "<", ">": begin
          tok_start = pos;
          held = c;
          scan_mode = M_HOLDOP;
          return;
        end
        "+": k = K_PLUS;
        "-": k = K_MINUS;
        "*": k = K_STAR;
        "(": k = K_LPAREN;
        ")": k = K_RPAREN;
        "{": k = K_LBRACE;
        "}": k = K_RBRACE;
        ";": k = K_SEMI;
        ",": k = K_COMMA;
        default: begin
          push_rec(K_ERR_CHAR, pos, 1, c);
          pass_byte(c);
          return;
        end
      endcase
      push_rec(k, pos, 1, 8'h0);
      pass_byte(c);
    endfunction

    // settle the held operator byte; c < 0 means end of source
    function void settle_op(int c);
      logic [7:0] h;
      logic [KIND_BITS-1:0] k;
      h = held;
      held = 8'h0;
      scan_mode = M_IDLE;
      if (h == "/") begin
        if (c == "/" || c == "*") begin
          pass_byte(h);
          pass_byte(c[7:0]);
          scan_mode = (c == "/") ? M_LINECMT : M_BLOCKCMT;
          return;
        end
        push_rec(K_SLASH, tok_start, 1, 8'h0);
      end else if (c == "=") begin
        pass_byte(h);
        k = (h == "=") ? K_EQEQ : (h == "!") ? K_BANGEQ : (h == "<") ? K_LE : K_GE;
        push_rec(k, tok_start, 2, 8'h0);
        pass_byte(c[7:0]);
        return;
      end else if (h == "!") begin
        push_rec(K_ERR_BANG, tok_start, 1, "!");
      end else begin
        k = (h == "=") ? K_EQ : (h == "<") ? K_LT : K_GT;
        push_rec(k, tok_start, 1, 8'h0);
      end
      pass_byte(h);
      if (c >= 0) open_token(c[7:0]);
    endfunction

    function void scan_byte(logic [7:0] c);
      case (scan_mode)
        M_IDLE: open_token(c);
        M_IDENT:
          if (alpha_c(c) || digit_c(c)) begin
            match_keywords(c);
            grow_len();
            pass_byte(c);
          end else begin
            close_ident();
            scan_mode = M_IDLE;
            open_token(c);
          end
        M_NUMBER:
          if (digit_c(c)) begin
            grow_len();
            pass_byte(c);
          end else if (c == "." && !dot_seen) begin
            held = ".";
            scan_mode = M_NUMDOT;
          end else begin
            push_rec(K_NUMBER, tok_start, tok_len, 8'h0);
            scan_mode = M_IDLE;
            open_token(c);
          end
        M_NUMDOT: begin
          held = 8'h0;
          if (digit_c(c)) begin
            pass_byte(".");
            grow_len();
            dot_seen = 1'b1;
            grow_len();
            pass_byte(c);
            scan_mode = M_NUMBER;
          end else begin
            push_rec(K_NUMBER, tok_start, tok_len, 8'h0);
            push_rec(K_ERR_CHAR, pos, 1, ".");
            pass_byte(".");
            scan_mode = M_IDLE;
            open_token(c);
          end
        end
        M_STRING:
          if (c == "\"") begin
            pass_byte(c);
            push_rec(K_STRING, tok_start, tok_len, 8'h0);
            scan_mode = M_IDLE;
          end else begin
            grow_len();
            pass_byte(c);
          end
        M_HOLDOP: settle_op(c);
        M_LINECMT:
          if (c == 8'h0a) begin
            scan_mode = M_IDLE;
            open_token(c);
          end else begin
            pass_byte(c);
          end
        M_BLOCKCMT:
          if (c == "*") begin
            held = "*";
            scan_mode = M_BLOCKSTAR;
          end else begin
            pass_byte(c);
          end
        M_BLOCKSTAR: begin
          pass_byte("*");
          held = 8'h0;
          if (c == "/") begin
            pass_byte(c);
            scan_mode = M_IDLE;
          end else if (c == "*") begin
            held = "*";
          end else begin
            pass_byte(c);
            scan_mode = M_BLOCKCMT;
          end
        end
        default: ;
      endcase
    endfunction

    function void close_source();
      case (scan_mode)
        M_IDENT: close_ident();
        M_NUMBER: push_rec(K_NUMBER, tok_start, tok_len, 8'h0);
        M_NUMDOT: begin
          push_rec(K_NUMBER, tok_start, tok_len, 8'h0);
          push_rec(K_ERR_CHAR, pos, 1, ".");
          pass_byte(".");
          held = 8'h0;
        end
        M_STRING: begin
          push_rec(K_ERR_STR, pos, 0, 8'h0);
          if (col_no != LC_MAX) col_no++;
          push_rec(K_STRING, tok_start, tok_len, 8'h0);
        end
        M_HOLDOP: settle_op(-1);
        M_BLOCKSTAR, M_BLOCKCMT: begin
          if (scan_mode == M_BLOCKSTAR) begin
            pass_byte("*");
            held = 8'h0;
          end
          push_rec(K_ERR_CMT, pos, 0, 8'h0);
          scan_mode = M_DONE;
          return;
        end
        M_IDLE, M_LINECMT: ;
        default: return;
      endcase
      push_rec(K_EOF, pos, 0, 8'h0);
      scan_mode = M_DONE;
    endfunction

    // one accepted input transaction
    function void note_input(logic [7:0] c, logic is_end);
      n_inputs++;
      burst.delete();
      if (scan_mode == M_DONE) return;
      if (is_end || c == 8'h0) close_source();
      else scan_byte(c);
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) pending.insert(pending.size(), burst[i]);
    endfunction

    // one accepted output transaction
    function void check_record(rec_t got);
      rec_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected record kind %0d", got.kind);
        fails++;
        return;
      end
      exp_r = pending.pop_front();
      n_records++;
      kinds_seen[got.kind] = 1'b1;
      if (got.kind !== exp_r.kind) begin
        $error("kind: expected %0d, got %0d", exp_r.kind, got.kind); fails++;
      end
      if (got.line !== exp_r.line) begin
        $error("line: expected %0d, got %0d", exp_r.line, got.line); fails++;
      end
      if (got.column !== exp_r.column) begin
        $error("column: expected %0d, got %0d", exp_r.column, got.column); fails++;
      end
      if (got.start !== exp_r.start) begin
        $error("start_offset: expected %0d, got %0d", exp_r.start, got.start); fails++;
      end
      if (got.len !== exp_r.len) begin
        $error("length: expected %0d, got %0d", exp_r.len, got.len); fails++;
      end
      if (got.bad !== exp_r.bad) begin
        $error("bad_char: expected %0h, got %0h", exp_r.bad, got.bad); fails++;
      end
      if (got.last !== exp_r.last) begin
        $error("last: expected %0b, got %0b", exp_r.last, got.last); fails++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'h0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TDATA_BITS-1:0] out_tdata;
  logic [KIND_BITS-1:0]  out_tuser;
  logic                  out_tlast;

  token_scoreboard sb = new();
  logic [7:0] src[$];       // source text to stream; 0 never appears before the end
  int         end_case;
  bit         calm = 1'b0;  // no idling in the closing stretch
  int         hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  source_tokenizer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // Sample both handshakes with pre-edge values.
  always @(posedge clk) begin
    rec_t got;
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata, in_tuser);
    if (rst_n && out_tvalid && out_tready) begin
      got.kind   = out_tuser;
      got.line   = out_tdata[23:0];
      got.column = out_tdata[47:24];
      got.start  = out_tdata[79:48];
      got.len    = out_tdata[95:80];
      got.bad    = out_tdata[103:96];
      got.last   = out_tlast;
      sb.check_record(got);
    end
  end

  // Receiver backpressure: random stall bursts.
  always @(posedge clk) begin
    logic rdy;
    rdy = 1'b1;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rdy = 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      hold_left <= $urandom_range(0, 3);
      rdy = 1'b0;
    end
    out_tready <= rdy;
  end

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void add_byte(logic [7:0] b);
    src.insert(src.size(), b);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // one random lexical piece, well formed most of the time
  function automatic void add_piece();
    string kws[12] = '{"let", "const", "function", "return", "if", "else",
                       "while", "for", "int", "float", "string", "bool"};
    string ops[20] = '{"+", "-", "*", "/", "=", "==", "!=", ">", "<", ">=", "<=",
                       "(", ")", "{", "}", ";", ",", "!", "!x", "=<"};
    string alnum;
    int n;
    alnum = "abcxyzABZ_0159";
    case ($urandom_range(0, 11))
      0, 1: add_text(kws[$urandom_range(0, 11)]);
      2: begin
        add_text(kws[$urandom_range(0, 11)]);
        if ($urandom_range(0, 1)) add_byte(pick(alnum));
        else void'(src.pop_back());
      end
      3: begin
        add_byte(pick("abqzAQZ_"));
        n = $urandom_range(0, 5);
        repeat (n) add_byte(pick(alnum));
      end
      4: begin
        n = $urandom_range(1, 4);
        repeat (n) add_byte(pick("0123456789"));
        case ($urandom_range(0, 3))
          0: add_text(".25");
          1: add_text(".");
          2: add_text("..5");
          default: ;
        endcase
      end
      5: begin
        add_byte("\"");
        n = $urandom_range(0, 5);
        repeat (n) begin
          logic [7:0] b;
          b = 8'($urandom_range(1, 255));
          if (b == "\"") b = "a";
          add_byte(b);
        end
        add_byte("\"");
      end
      6, 7: add_text(ops[$urandom_range(0, 19)]);
      8: begin
        add_text("//");
        n = $urandom_range(0, 4);
        repeat (n) add_byte(pick("ab */\"x"));
        add_byte(8'h0a);
      end
      9: begin
        add_text("/*");
        n = $urandom_range(0, 5);
        repeat (n) add_byte(pick("a*/ \n*"));
        add_text($urandom_range(0, 1) ? "*/" : "**/");
      end
      10: add_byte(8'($urandom_range(1, 255)));
      default: add_byte(pick(" \t\n\v\f\r"));
    endcase
    if ($urandom_range(0, 2) == 0) add_byte(pick("  \n\t"));
  endfunction

  task automatic send_item(logic [7:0] b, logic e, bit may_idle);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= e;
    do @(posedge clk); while (!in_tready);
    if (may_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int n_src;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: two-byte operators, lone bang, unknown bytes, lone and double dots.
    add_text("a==b!=c<=d>=e!x@1.2.3.q 9.\"\"");
    add_byte(8'hff);
    add_byte(8'h80);
    add_text("letx if_");
    add_byte(8'h0a);
    while (src.size() < 310) add_piece();

    // How the source ends: each exercises a different flush path.
    end_case = $urandom_range(0, 7);
    case (end_case)
      0: add_text(" \"open");
      1: add_text(" /* open *");
      2: add_text(" /* open");
      3: add_text(" 42.");
      4: add_byte(pick("/=!<>"));
      5: add_text(" name");
      6: add_text(" // tail");
      default: ;
    endcase

    n_src = src.size();
    foreach (src[i]) begin
      if (i >= n_src - 40) calm = 1'b1;
      send_item(src[i], 1'b0, !calm);
    end
    // A zero byte or the end flag closes the source; ch is random with the flag.
    if ($urandom_range(0, 1)) send_item(8'h0, 1'b0, 1'b0);
    else send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    // These come after the end and must be dropped.
    send_item(8'hff, 1'b0, 1'b0);
    send_item("a", 1'b1, 1'b0);
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Streamed %0d bytes (end variant %0d); checked %0d token records.",
             sb.n_inputs, end_case, sb.n_records);
    $display("Distinct record kinds observed: %0d of 37.", $countones(sb.kinds_seen));
    if (sb.fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule
